// ----- hdl/hkm_pkg.sv -----
// Shared constants and controller/datapath interface types for the HID key tracker.
package hkm_pkg;

    localparam int HELD_SLOTS_DEF = 8;

    localparam int CMD_W      = 2;
    localparam int KEY_W      = 8;
    localparam int MOD_BITS   = 8;
    localparam int MOD_IW     = 3;
    localparam int CNT_W      = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [CMD_W-1:0] CMD_PRESS       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 2'd2;

    localparam logic [CMD_W-1:0] ACT_PRESS       = 2'd0;
    localparam logic [CMD_W-1:0] ACT_RELEASE     = 2'd1;
    localparam logic [CMD_W-1:0] ACT_RELEASE_ALL = 2'd2;

    localparam logic [KEY_W-1:0] MOD_USAGE_BASE = 8'hE0;
    localparam logic [CNT_W-1:0] COUNT_MAX      = 8'hFF;

    typedef struct packed {
        logic load;
        logic clear_all;
        logic inc_mods;
        logic scan_step;
        logic write_slot;
        logic apply_release;
        logic emit_key;
        logic emit_mod;
    } hkm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_done;
        logic is_press;
        logic pend_empty;
        logic pend_single;
    } hkm_stat_t;

endpackage

// ----- hdl/hid_key_modifier_refcount_tracker_unit.sv -----
// Top level of the HID key and modifier reference-count tracker.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: command, keycode, modifier_mask
//  m_      | out       | m_tvalid/m_tready  | m_tdata: action, usage; m_tlast: last
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data: enabled
//
// Press: accept, a key event and one event per modifier in the mask, then a slot scan of up to
// HELD_SLOTS slots through the table memory's single read port.
// Release: accept, a scan of up to HELD_SLOTS slots, then a key event and one event per
// released modifier.
// Release all emits one event; a dropped command emits none. Events wait on m_tready.
// Reset clears the table valid bits and counts at once; no clearing pass.
module hid_key_modifier_refcount_tracker_unit #(
    parameter int HELD_SLOTS = hkm_pkg::HELD_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hkm_pkg::S_TDATA_W-1:0] s_tdata,  // command[1:0], keycode[9:2], modifier_mask[17:10]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hkm_pkg::M_TDATA_W-1:0] m_tdata,  // action[1:0], usage[9:2]
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data
);
    import hkm_pkg::*;

    hkm_cmd_t  ctl_cmd;
    hkm_stat_t dp_stat;

    hkm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_command   (s_tdata[CMD_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (ctl_cmd),
        .stat        (dp_stat)
    );

    hkm_datapath #(
        .HELD_SLOTS (HELD_SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (ctl_cmd),
        .stat     (dp_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_cmd.emit_key || ctl_cmd.emit_mod) |-> dp_stat.out_free)
        else $error("event emitted while output register is occupied");

    a_mod_has_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.emit_mod |-> !dp_stat.pend_empty)
        else $error("modifier event emitted with no pending modifier");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tlast))
        else $error("new command taken before the previous one finished");

    a_load_restarts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_cmd.load |=> !dp_stat.scan_done)
        else $error("scan result not cleared by a new command");
`endif

endmodule

// ----- hdl/hkm_ctrl.sv -----
// Command sequencer: accepts commands and steps the datapath through scan and event emission.
module hkm_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [hkm_pkg::CMD_W-1:0] s_command,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    output hkm_pkg::hkm_cmd_t         cmd,
    input  hkm_pkg::hkm_stat_t        stat
);
    import hkm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_KEY,
        ST_MODS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   enabled_reg;

    assign s_tready = s_tready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg && enabled_reg) begin
                    case (s_command)
                        CMD_PRESS: begin
                            cmd.load     = 1'b1;
                            cmd.inc_mods = 1'b1;
                            state_next   = ST_KEY;
                        end
                        CMD_RELEASE: begin
                            cmd.load   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        CMD_RELEASE_ALL: begin
                            cmd.load      = 1'b1;
                            cmd.clear_all = 1'b1;
                            state_next    = ST_KEY;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    if (stat.is_press) begin
                        cmd.write_slot = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.apply_release = 1'b1;
                        state_next        = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                if (stat.out_free) begin
                    cmd.emit_key = 1'b1;
                    if (!stat.pend_empty) begin
                        state_next = ST_MODS;
                    end else if (stat.is_press) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MODS: begin
                if (stat.out_free) begin
                    cmd.emit_mod = 1'b1;
                    if (stat.pend_single) begin
                        state_next = stat.is_press ? ST_SCAN : ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            enabled_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
            if (cfg_wr_en) begin
                enabled_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ----- hdl/hkm_datapath.sv -----
// Held-key table, modifier reference counts, slot scan and output event register.
module hkm_datapath #(
    parameter int HELD_SLOTS = hkm_pkg::HELD_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hkm_pkg::S_TDATA_W-1:0] s_tdata,
    input  hkm_pkg::hkm_cmd_t             cmd,
    output hkm_pkg::hkm_stat_t            stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hkm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import hkm_pkg::*;

    localparam int SLOT_IW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
    localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(HELD_SLOTS - 1);

    logic [CMD_W-1:0]    in_cmd;
    logic [KEY_W-1:0]    in_key;
    logic [MOD_BITS-1:0] in_mask;

    logic [CMD_W-1:0]    op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [MOD_BITS-1:0] mask_reg;
    logic [MOD_BITS-1:0] pend_reg;
    logic [CNT_W-1:0]    cnt_reg [MOD_BITS];
    logic [HELD_SLOTS-1:0] slot_vld_reg;

    logic [KEY_W-1:0]    key_mem  [HELD_SLOTS];
    logic [MOD_BITS-1:0] mods_mem [HELD_SLOTS];

    logic                rd_vld_reg;
    logic [SLOT_IW-1:0]  rd_idx_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [MOD_BITS-1:0] rd_mods_reg;
    logic                rd_slot_vld_reg;

    logic                m_tvalid_reg;
    logic [CMD_W-1:0]    out_action_reg;
    logic [KEY_W-1:0]    out_usage_reg;
    logic                out_last_reg;

    logic [KEY_W-1:0]    target;
    logic [KEY_W-1:0]    eff_key;
    logic [MOD_BITS-1:0] eff_mods;
    logic                hit;
    logic                scan_done;
    logic [SLOT_IW-1:0]  rd_addr;
    logic [MOD_BITS-1:0] held;
    logic [MOD_BITS-1:0] rel_emit;
    logic [MOD_BITS-1:0] pend_rest;
    logic [MOD_IW-1:0]   low_idx;
    logic [CMD_W-1:0]    key_action;
    logic [CMD_W-1:0]    mod_action;
    logic                out_free;

    assign in_cmd  = s_tdata[CMD_W-1:0];
    assign in_key  = s_tdata[CMD_W+KEY_W-1:CMD_W];
    assign in_mask = s_tdata[CMD_W+KEY_W+MOD_BITS-1:CMD_W+KEY_W];

    assign target    = (op_reg == CMD_PRESS) ? '0 : key_reg;
    assign eff_key   = rd_slot_vld_reg ? rd_key_reg : '0;
    assign eff_mods  = rd_slot_vld_reg ? rd_mods_reg : '0;
    assign hit       = rd_vld_reg && (eff_key == target);
    assign scan_done = rd_vld_reg && (hit || (rd_idx_reg == LAST_SLOT));
    assign rd_addr   = rd_vld_reg ? rd_idx_reg + SLOT_IW'(1) : '0;
    assign held      = hit ? eff_mods : '0;
    assign pend_rest = pend_reg & (pend_reg - MOD_BITS'(1));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        for (int b = 0; b < MOD_BITS; b++) begin
            rel_emit[b] = held[b] && (cnt_reg[b] <= CNT_W'(1));
        end
    end

    always_comb begin
        low_idx = '0;
        for (int b = MOD_BITS - 1; b >= 0; b--) begin
            if (pend_reg[b]) begin
                low_idx = MOD_IW'(b);
            end
        end
    end

    always_comb begin
        case (op_reg)
            CMD_PRESS:       key_action = ACT_PRESS;
            CMD_RELEASE:     key_action = ACT_RELEASE;
            CMD_RELEASE_ALL: key_action = ACT_RELEASE_ALL;
            default:         key_action = ACT_RELEASE_ALL;
        endcase
        mod_action = (op_reg == CMD_PRESS) ? ACT_PRESS : ACT_RELEASE;
    end

    assign stat.out_free    = out_free;
    assign stat.scan_done   = scan_done;
    assign stat.is_press    = (op_reg == CMD_PRESS);
    assign stat.pend_empty  = (pend_reg == '0);
    assign stat.pend_single = (pend_rest == '0);

    // slot table memory
    always_ff @(posedge aclk) begin
        if (cmd.write_slot && hit) begin
            key_mem[rd_idx_reg]  <= key_reg;
            mods_mem[rd_idx_reg] <= mask_reg;
        end
        if (cmd.scan_step && !scan_done) begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_mods_reg <= mods_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_cmd;
            key_reg  <= in_key;
            mask_reg <= in_mask;
        end
        if (cmd.scan_step && !scan_done) begin
            rd_idx_reg      <= rd_addr;
            rd_slot_vld_reg <= slot_vld_reg[rd_addr];
        end
        if (cmd.emit_key) begin
            out_action_reg <= key_action;
            out_usage_reg  <= (op_reg == CMD_RELEASE_ALL) ? '0 : key_reg;
            out_last_reg   <= (pend_reg == '0);
        end else if (cmd.emit_mod) begin
            out_action_reg <= mod_action;
            out_usage_reg  <= MOD_USAGE_BASE | KEY_W'(low_idx);
            out_last_reg   <= (pend_rest == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            slot_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int b = 0; b < MOD_BITS; b++) begin
                cnt_reg[b] <= '0;
            end
        end else begin
            if (cmd.load) begin
                pend_reg   <= (in_cmd == CMD_PRESS) ? in_mask : '0;
                rd_vld_reg <= 1'b0;
            end
            if (cmd.clear_all) begin
                slot_vld_reg <= '0;
                for (int b = 0; b < MOD_BITS; b++) begin
                    cnt_reg[b] <= '0;
                end
            end
            if (cmd.inc_mods) begin
                for (int b = 0; b < MOD_BITS; b++) begin
                    if (in_mask[b] && (cnt_reg[b] != COUNT_MAX)) begin
                        cnt_reg[b] <= cnt_reg[b] + CNT_W'(1);
                    end
                end
            end
            if (cmd.scan_step) begin
                rd_vld_reg <= !scan_done;
            end
            if (cmd.write_slot && hit) begin
                slot_vld_reg[rd_idx_reg] <= 1'b1;
            end
            if (cmd.apply_release) begin
                if (hit) begin
                    slot_vld_reg[rd_idx_reg] <= 1'b0;
                end
                for (int b = 0; b < MOD_BITS; b++) begin
                    if (held[b] && (cnt_reg[b] != '0)) begin
                        cnt_reg[b] <= cnt_reg[b] - CNT_W'(1);
                    end
                end
                pend_reg <= rel_emit;
            end
            if (cmd.emit_mod) begin
                pend_reg <= pend_rest;
            end
            if (cmd.emit_key || cmd.emit_mod) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - KEY_W - CMD_W){1'b0}}, out_usage_reg, out_action_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- verif/tb.sv -----
// Testbench for the HID key and modifier reference-count tracker: directed table plus random commands.
`timescale 1ns / 100ps

module tb;
    import hkm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_CYCLES = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AFTER   = 100;

    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_TOGGLE = 2;
    localparam int RX_SPARSE = 3;

    typedef struct packed {
        logic [CMD_W-1:0] action;
        logic [KEY_W-1:0] usage;
        logic             last;
    } hid_event_t;

    typedef enum logic {ROW_CMD, ROW_ENABLE} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic             cfg_val;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [7:0]       mask;
        logic             typed;
        logic             typed_one;
        logic [CMD_W-1:0] t_act;
        logic [KEY_W-1:0] t_usage;
    } stim_row_t;

    localparam stim_row_t SCRIPT [24] = '{
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h04, 8'hFF, 1'b1, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE_ALL, 8'h00, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_ENABLE, 1'b1, CMD_PRESS,       8'h00, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h04, 8'h00, 1'b1, 1'b1, ACT_PRESS,       8'h04},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'hFF, 8'hFF, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h05, 8'h01, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE,     8'hFF, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE,     8'h33, 8'hFF, 1'b1, 1'b1, ACT_RELEASE,     8'h33},
        '{ROW_CMD,    1'b0, CMD_UNUSED,      8'hAA, 8'h55, 1'b1, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE_ALL, 8'h00, 8'h00, 1'b1, 1'b1, ACT_RELEASE_ALL, 8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h00, 8'h81, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE,     8'h00, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h10, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h11, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h12, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h13, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h14, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h15, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h16, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h17, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_PRESS,       8'h18, 8'h02, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE,     8'h18, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE,     8'h10, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
        '{ROW_CMD,    1'b0, CMD_RELEASE_ALL, 8'h00, 8'h00, 1'b1, 1'b1, ACT_RELEASE_ALL, 8'h00}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;

    logic             kbd_enabled;
    logic [KEY_W-1:0] held_key [HELD_SLOTS_DEF];
    logic [7:0]       held_mods [HELD_SLOTS_DEF];
    logic [CNT_W-1:0] mod_count [MOD_BITS];

    hid_event_t next_events[$];
    hid_event_t expected_events[$];

    int fail_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_armed = 1'b1;
    int rx_mode = RX_OPEN;
    int rx_left = 0;

    hid_key_modifier_refcount_tracker_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic void predict_events(input logic [CMD_W-1:0] cmd,
                                           input logic [KEY_W-1:0] key,
                                           input logic [7:0] mask);
        logic [7:0] held;
        next_events.delete();
        if (!kbd_enabled || cmd == CMD_UNUSED) return;
        case (cmd)
            CMD_PRESS: begin
                next_events.push_back('{action: ACT_PRESS, usage: key, last: 1'b0});
                for (int b = 0; b < MOD_BITS; b++) begin
                    if (mask[b]) begin
                        next_events.push_back('{action: ACT_PRESS,
                                                usage: MOD_USAGE_BASE + 8'(b), last: 1'b0});
                        if (mod_count[b] != COUNT_MAX) mod_count[b]++;
                    end
                end
                for (int s = 0; s < HELD_SLOTS_DEF; s++) begin
                    if (held_key[s] == '0) begin
                        held_key[s] = key;
                        held_mods[s] = mask;
                        break;
                    end
                end
            end
            CMD_RELEASE: begin
                next_events.push_back('{action: ACT_RELEASE, usage: key, last: 1'b0});
                for (int s = 0; s < HELD_SLOTS_DEF; s++) begin
                    if (held_key[s] == key) begin
                        held = held_mods[s];
                        for (int b = 0; b < MOD_BITS; b++) begin
                            if (held[b]) begin
                                if (mod_count[b] != '0) mod_count[b]--;
                                if (mod_count[b] == '0)
                                    next_events.push_back('{action: ACT_RELEASE,
                                        usage: MOD_USAGE_BASE + 8'(b), last: 1'b0});
                            end
                        end
                        held_key[s] = '0;
                        held_mods[s] = '0;
                        break;
                    end
                end
            end
            default: begin
                for (int s = 0; s < HELD_SLOTS_DEF; s++) begin
                    held_key[s] = '0;
                    held_mods[s] = '0;
                end
                for (int b = 0; b < MOD_BITS; b++) mod_count[b] = '0;
                next_events.push_back('{action: ACT_RELEASE_ALL, usage: 8'h00, last: 1'b0});
            end
        endcase
        next_events[next_events.size() - 1].last = 1'b1;
    endfunction

    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [7:0] mask, input logic typed,
                                 input logic typed_one, input hid_event_t typed_ev);
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, mask, key, cmd};
        do @(posedge aclk); while (!s_tready);
        predict_events(cmd, key, mask);
        if (typed) begin
            if (typed_one) expected_events.push_back(typed_ev);
        end else begin
            foreach (next_events[k]) expected_events.push_back(next_events[k]);
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (expected_events.size() != 0) @(posedge aclk);
    endtask

    task automatic set_enabled(input logic value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        kbd_enabled = value;
    endtask

    task automatic random_commands(input int count, input int pause_at);
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [7:0]       mask;
        logic [KEY_W-1:0] held_now[$];
        int               r;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            key = 8'($urandom_range(0, 255));
            mask = 8'($urandom_range(0, 255));
            if (r < 45) begin
                cmd = CMD_PRESS;
                if ($urandom_range(0, 4) != 0) key = 8'($urandom_range(1, 12));
                r = $urandom_range(0, 99);
                if (r < 40) mask = 8'h01 << $urandom_range(0, 7);
                else if (r < 55) mask = 8'h00;
                else if (r < 65) mask = 8'hFF;
                else if (r < 75) mask = (8'h01 << $urandom_range(0, 7))
                                      | (8'h01 << $urandom_range(0, 7));
            end else if (r < 80) begin
                cmd = CMD_RELEASE;
                held_now.delete();
                foreach (held_key[s]) if (held_key[s] != '0) held_now.push_back(held_key[s]);
                if (held_now.size() != 0)
                    key = held_now[$urandom_range(0, held_now.size() - 1)];
            end else if (r < 88) begin
                cmd = CMD_RELEASE;
            end else if (r < 94) begin
                cmd = CMD_RELEASE_ALL;
            end else begin
                cmd = CMD_UNUSED;
            end
            offer_command(cmd, key, mask, 1'b0, 1'b0, '0);
            pace();
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_armed && results_seen >= HOLD_AFTER) begin
            hold_armed <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(RX_OPEN, RX_SPARSE);
                rx_left <= $urandom_range(20, 100);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: m_tready <= ~m_tready;
                default:   m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        hid_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
                $error("unexpected transfer: action %0d usage 0x%02h last %0b",
                       m_tdata[1:0], m_tdata[9:2], m_tlast);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                if (m_tdata[1:0] !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[9:2] !== want.usage) begin
                    $error("usage: expected 0x%02h, got 0x%02h", want.usage, m_tdata[9:2]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        kbd_enabled = 1'b0;
        foreach (held_key[s]) begin
            held_key[s] = '0;
            held_mods[s] = '0;
        end
        foreach (mod_count[b]) mod_count[b] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_ENABLE) begin
                set_enabled(SCRIPT[i].cfg_val);
            end else begin
                offer_command(SCRIPT[i].cmd, SCRIPT[i].key, SCRIPT[i].mask, SCRIPT[i].typed,
                              SCRIPT[i].typed_one,
                              '{action: SCRIPT[i].t_act, usage: SCRIPT[i].t_usage, last: 1'b1});
                pace();
            end
        end

        random_commands(60, 45);
        random_commands(40, -1);
        set_enabled(1'b0);
        random_commands(12, -1);
        set_enabled(1'b1);
        random_commands(35, 20);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/hkm_pkg.sv
hdl/hkm_ctrl.sv
hdl/hkm_datapath.sv
hdl/hid_key_modifier_refcount_tracker_unit.sv
verif/tb.sv
